FILE: design/rmc_pkg.sv
// Shared types, constants and register indexes of the run-length mask crop block.
package rmc_pkg;

   localparam int DIM_BITS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 32;
   localparam int RUN_LEN_BITS   = 32;
   localparam int OUT_LEN_BITS   = 32;
   localparam int CSR_ADDR_BITS  = 3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_HEIGHT = 3'd0,
      CSR_IMAGE_WIDTH  = 3'd1,
      CSR_BOX_LEFT     = 3'd2,
      CSR_BOX_TOP      = 3'd3,
      CSR_BOX_WIDTH    = 3'd4,
      CSR_BOX_HEIGHT   = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOX,
      ST_MUL_BS,
      ST_ADD_BS,
      ST_ADD_BE,
      ST_CHECK,
      ST_DIV_RE,
      ST_DIV_RS,
      ST_DECIDE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [OUT_LEN_BITS-1:0] out_length;
      logic                    out_value;
      logic                    out_last;
      logic                    out_empty;
   } result_type;

endpackage

FILE: design/rmc_div_unit.sv
// Iterative restoring divider that folds min(x % h, s) + s * (x / h) into one pass.
module rmc_div_unit
   import rmc_pkg::*;
#(
   parameter int DIM_BITS   = DIM_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] dividend,
   input  logic [DIM_BITS-1:0]   divisor,
   input  logic [DIM_BITS-1:0]   scale,
   output logic                  done,
   output logic [COUNT_BITS-1:0] result
);

   localparam int CNT_W = $clog2(COUNT_BITS + 1);

   logic                  run_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [COUNT_BITS-1:0] dividend_ff;
   logic [DIM_BITS-1:0]   rem_ff;
   logic [COUNT_BITS-1:0] acc_ff;

   logic [DIM_BITS:0]     shifted;
   logic [DIM_BITS:0]     diff;
   logic                  ge;
   logic [DIM_BITS-1:0]   rem_in;
   logic [COUNT_BITS-1:0] acc_in;
   logic [DIM_BITS-1:0]   rem_clip;

   // One quotient bit per cycle; the scaled quotient builds up MSB first.
   assign shifted = {rem_ff, dividend_ff[COUNT_BITS-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign ge      = shifted >= {1'b0, divisor};
   assign rem_in  = ge ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
   assign acc_in  = {acc_ff[COUNT_BITS-2:0], 1'b0} + (ge ? COUNT_BITS'(scale) : '0);

   assign done     = run_ff && (count_ff == '0);
   assign rem_clip = (rem_ff < scale) ? rem_ff : scale;
   assign result   = COUNT_BITS'(rem_clip) + acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         run_ff   <= 1'b1;
         count_ff <= CNT_W'(COUNT_BITS);
      end else if (run_ff) begin
         if (count_ff == '0) begin
            run_ff <= 1'b0;
         end else begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         rem_ff      <= '0;
         acc_ff      <= '0;
      end else if (run_ff && (count_ff != '0)) begin
         dividend_ff <= {dividend_ff[COUNT_BITS-2:0], 1'b0};
         rem_ff      <= rem_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

FILE: design/rle_mask_crop.sv
// Top level of the column-major run-length mask crop block.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   req     | in        | req_valid/ready    | run_length, last_run
//   rsp     | out       | rsp_valid/ready    | out_length, out_value, out_last, out_empty
//   csr     | in        | csr_we (no wait)   | csr_addr, csr_wdata
//
// A run that overlaps the box goes from acceptance through ST_BOX, ST_MUL_BS, ST_ADD_BS,
// ST_ADD_BE, ST_CHECK and the two divider passes (ST_DIV_RE, ST_DIV_RS) to the decision.
// A run that misses the box skips the divider and goes from ST_CHECK to the decision;
// with an empty crop box the block goes from ST_BOX straight to ST_SEND or ST_IDLE.
// req_ready is high only in the idle state; results wait in a two-entry output
// buffer and a stalled rsp side holds the block there. Reset is synchronous.
module rle_mask_crop
   import rmc_pkg::*;
#(
   parameter int DIM_BITS   = DIM_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RUN_LEN_BITS-1:0]  req_run_length,
   input  logic                     req_last_run,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OUT_LEN_BITS-1:0]  rsp_out_length,
   output logic                     rsp_out_value,
   output logic                     rsp_out_last,
   output logic                     rsp_out_empty,

   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [DIM_BITS-1:0]      csr_wdata
);

   localparam int DW = DIM_BITS;
   localparam int CW = COUNT_BITS;
   localparam int PW = 2 * DIM_BITS;

   // configuration registers
   logic [DW-1:0] image_height_ff, image_width_ff;
   logic [DW-1:0] box_left_ff, box_top_ff, box_width_ff, box_height_ff;

   // mask state carried from run to run
   logic [CW-1:0] run_start_ff;
   logic          parity_ff;
   logic [CW-1:0] pend_len_ff;
   logic          pend_val_ff;
   logic          pend_valid_ff;
   logic          first_ff;

   // per-run working registers
   state_type     state_ff, state_in;
   logic [CW-1:0] start_ff, end_ff;
   logic          val_ff, last_ff;
   logic [DW-1:0] x0_ff, y0_ff, bw_ff, bh_ff, xe_ff;
   logic [PW-1:0] prod_ff;
   logic [CW-1:0] bs_ff, be_ff, rs_ff, fre_ff, c_ff;

   // output buffer
   result_type    slot_ff [2];
   logic [1:0]    n_ff;
   logic          head_ff;

   // combinational helpers
   logic [DW-1:0] x0_c, y0_c, wrem_c, hrem_c, bw_c, bh_c;
   logic          empty_c;
   logic [DW-1:0] mul_a;
   logic [PW-1:0] prod_in;
   logic          overlap_c;
   logic [CW-1:0] rs_c, re_c;
   logic [CW-1:0] run_end_c;

   logic          div_start, div_done;
   logic [CW-1:0] div_dividend, div_result;

   logic [CW-1:0] pend_len_in;
   logic          pend_val_in, pend_valid_in, first_in, flush_c;
   result_type    res_flush, res_fin, res_empty, slot0_in, slot1_in;
   logic [1:0]    n_in;

   logic          req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------- config port
   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= '0;
         image_width_ff  <= '0;
         box_left_ff     <= '0;
         box_top_ff      <= '0;
         box_width_ff    <= '0;
         box_height_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_BOX_LEFT:     box_left_ff     <= csr_wdata;
            CSR_BOX_TOP:      box_top_ff      <= csr_wdata;
            CSR_BOX_WIDTH:    box_width_ff    <= csr_wdata;
            CSR_BOX_HEIGHT:   box_height_ff   <= csr_wdata;
            default: ;  // drop writes past the last register
         endcase
      end
   end

   // ---------------------------------------------------------------- box clipping
   assign x0_c    = (box_left_ff < image_width_ff) ? box_left_ff : image_width_ff;
   assign y0_c    = (box_top_ff < image_height_ff) ? box_top_ff : image_height_ff;
   assign wrem_c  = image_width_ff - x0_c;
   assign hrem_c  = image_height_ff - y0_c;
   assign bw_c    = (box_width_ff < wrem_c) ? box_width_ff : wrem_c;
   assign bh_c    = (box_height_ff < hrem_c) ? box_height_ff : hrem_c;
   assign empty_c = (bw_c == '0) || (bh_c == '0) || (image_height_ff == '0);

   // One multiplier serves the box start and the box end on successive cycles.
   assign mul_a   = (state_ff == ST_MUL_BS) ? x0_ff : xe_ff;
   assign prod_in = PW'(mul_a) * PW'(image_height_ff);

   // Overlap of the run with the box span, relative to the box start.
   assign overlap_c = !((end_ff <= bs_ff) || (start_ff >= be_ff));
   assign rs_c      = ((start_ff > bs_ff) ? start_ff : bs_ff) - bs_ff;
   assign re_c      = ((end_ff < be_ff) ? end_ff : be_ff) - bs_ff;

   assign run_end_c = run_start_ff + CW'(req_run_length);

   // ---------------------------------------------------------------- shared divider
   rmc_div_unit #(
      .DIM_BITS  (DIM_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (image_height_ff),
      .scale   (bh_ff),
      .done    (div_done),
      .result  (div_result)
   );

   // ---------------------------------------------------------------- merge decision
   always_comb begin
      pend_len_in   = pend_len_ff;
      pend_val_in   = pend_val_ff;
      pend_valid_in = pend_valid_ff;
      first_in      = first_ff;
      flush_c       = 1'b0;
      priority if (first_ff) begin
         // keep the first output run even when it is empty
         pend_len_in   = c_ff;
         pend_val_in   = val_ff;
         pend_valid_in = 1'b1;
         first_in      = 1'b0;
      end else if (c_ff == '0) begin
         // drop zero-length runs
      end else if (pend_valid_ff && (val_ff == pend_val_ff)) begin
         pend_len_in = pend_len_ff + c_ff;
      end else begin
         flush_c       = pend_valid_ff;
         pend_len_in   = c_ff;
         pend_val_in   = val_ff;
         pend_valid_in = 1'b1;
      end
   end

   assign res_flush = '{out_length: OUT_LEN_BITS'(pend_len_ff), out_value: pend_val_ff,
                        out_last: 1'b0, out_empty: 1'b0};
   assign res_empty = '{out_length: '0, out_value: 1'b0, out_last: 1'b1, out_empty: 1'b1};
   assign res_fin   = pend_valid_in ?
                      result_type'{out_length: OUT_LEN_BITS'(pend_len_in),
                                   out_value: pend_val_in, out_last: 1'b1,
                                   out_empty: 1'b0} : res_empty;

   always_comb begin
      if (flush_c) begin
         slot0_in = res_flush;
         slot1_in = res_fin;
         n_in     = last_ff ? 2'd2 : 2'd1;
      end else begin
         slot0_in = res_fin;
         slot1_in = res_fin;
         n_in     = last_ff ? 2'd1 : 2'd0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      div_start    = 1'b0;
      div_dividend = re_c;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_BOX;
            end
         end
         ST_BOX: begin
            priority if (!empty_c) begin
               state_in = ST_MUL_BS;
            end else if (last_ff) begin
               state_in = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL_BS: state_in = ST_ADD_BS;
         ST_ADD_BS: state_in = ST_ADD_BE;
         ST_ADD_BE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (overlap_c) begin
               div_start = 1'b1;
               state_in  = ST_DIV_RE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DIV_RE: begin
            div_dividend = rs_ff;
            if (div_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_RS;
            end
         end
         ST_DIV_RS: begin
            if (div_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = (n_in == 2'd0) ? ST_IDLE : ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready && (head_ff || (n_ff == 2'd1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- mask state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff  <= '0;
         parity_ff     <= 1'b0;
         pend_len_ff   <= '0;
         pend_val_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         first_ff      <= 1'b1;
         head_ff       <= 1'b0;
         n_ff          <= '0;
      end else begin
         if (req_fire) begin
            // advance position and parity for every run, cropped or not
            run_start_ff <= run_end_c;
            parity_ff    <= !parity_ff;
         end
         if ((state_ff == ST_BOX) && empty_c && last_ff) begin
            // empty box: discard the held-back run and restart the mask
            run_start_ff  <= '0;
            parity_ff     <= 1'b0;
            pend_len_ff   <= '0;
            pend_val_ff   <= 1'b0;
            pend_valid_ff <= 1'b0;
            first_ff      <= 1'b1;
            n_ff          <= 2'd1;
            head_ff       <= 1'b0;
         end
         if (state_ff == ST_DECIDE) begin
            if (last_ff) begin
               run_start_ff  <= '0;
               parity_ff     <= 1'b0;
               pend_len_ff   <= '0;
               pend_val_ff   <= 1'b0;
               pend_valid_ff <= 1'b0;
               first_ff      <= 1'b1;
            end else begin
               pend_len_ff   <= pend_len_in;
               pend_val_ff   <= pend_val_in;
               pend_valid_ff <= pend_valid_in;
               first_ff      <= first_in;
            end
            n_ff    <= n_in;
            head_ff <= 1'b0;
         end
         if (rsp_fire) begin
            head_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_ff <= run_start_ff;
         end_ff   <= run_end_c;
         val_ff   <= parity_ff;
         last_ff  <= req_last_run;
      end
      unique case (state_ff)
         ST_BOX: begin
            x0_ff      <= x0_c;
            y0_ff      <= y0_c;
            bw_ff      <= bw_c;
            bh_ff      <= bh_c;
            slot_ff[0] <= res_empty;
         end
         ST_MUL_BS: begin
            prod_ff <= prod_in;
            xe_ff   <= x0_ff + bw_ff - 1'b1;
         end
         ST_ADD_BS: begin
            bs_ff   <= CW'(prod_ff) + CW'(y0_ff);
            prod_ff <= prod_in;
         end
         ST_ADD_BE: begin
            be_ff <= CW'(prod_ff) + CW'(bh_ff) + CW'(y0_ff);
         end
         ST_CHECK: begin
            rs_ff <= rs_c;
            c_ff  <= '0;
         end
         ST_DIV_RE: begin
            if (div_done) begin
               fre_ff <= div_result;
            end
         end
         ST_DIV_RS: begin
            if (div_done) begin
               c_ff <= fre_ff - div_result;
            end
         end
         ST_DECIDE: begin
            slot_ff[0] <= slot0_in;
            slot_ff[1] <= slot1_in;
         end
         default: ;
      endcase
   end

   assign rsp_out_length = slot_ff[head_ff].out_length;
   assign rsp_out_value  = slot_ff[head_ff].out_value;
   assign rsp_out_last   = slot_ff[head_ff].out_last;
   assign rsp_out_empty  = slot_ff[head_ff].out_empty;

   // ---------------------------------------------------------------- assertions
   a_no_overlap_sides: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while results are pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready stayed high after an accepted run");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_empty) |->
         (rsp_out_last && (rsp_out_length == '0) && !rsp_out_value))
      else $error("empty result with stray payload");

   a_pending_after_first: assert property (@(posedge clock) disable iff (reset)
      !first_ff |-> pend_valid_ff)
      else $error("first run emitted but nothing held back");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV_RE) || (state_ff == ST_DIV_RS)))
      else $error("divider finished outside a divide step");

endmodule

FILE: tb/sv/rle_mask_crop_tb.sv
// Self-checking testbench of the run-length mask crop block: directed masks, then random phases.
module rle_mask_crop_tb;
   import rmc_pkg::*;

   localparam int CNT_W         = COUNT_BITS_DEF;
   localparam int DIM_W         = DIM_BITS_DEF;
   localparam int RANDOM_RUNS   = 850;
   localparam int MAX_WAIT      = 13;
   // one run goes through two divider passes plus its result transactions; leave slack
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 1000000;
   // indexes past the register file; writes to them must change nothing
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [RUN_LEN_BITS-1:0] run_length;
      logic                    last_run;
   } run_item_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [RUN_LEN_BITS-1:0]  req_run_length = '0;
   logic                     req_last_run   = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic [OUT_LEN_BITS-1:0]  rsp_out_length;
   logic                     rsp_out_value;
   logic                     rsp_out_last;
   logic                     rsp_out_empty;
   logic                     csr_we         = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr       = '0;
   logic [DIM_W-1:0]         csr_wdata      = '0;

   // register shadow, updated as each write is issued
   logic [DIM_W-1:0] img_h    = '0;
   logic [DIM_W-1:0] img_w    = '0;
   logic [DIM_W-1:0] left_col = '0;
   logic [DIM_W-1:0] top_row  = '0;
   logic [DIM_W-1:0] crop_w   = '0;
   logic [DIM_W-1:0] crop_h   = '0;

   // mask scan state: position and value of the next run, plus the held-back run
   logic [CNT_W-1:0] scan_pos       = '0;
   logic             scan_parity    = 1'b0;
   logic [CNT_W-1:0] held_len       = '0;
   logic             held_val       = 1'b0;
   logic             held_valid     = 1'b0;
   logic             awaiting_first = 1'b1;

   run_item_type runs_to_send[$];
   result_type   cropped_runs_due[$];

   int unsigned send_gap      = 0;
   int unsigned ready_wait    = 0;
   bit          send_idle_on  = 1'b1;
   bit          recv_stall_on = 1'b1;

   int unsigned error_count     = 0;
   int unsigned runs_queued     = 0;
   int unsigned runs_accepted   = 0;
   int unsigned masks_queued    = 0;
   int unsigned results_checked = 0;
   int unsigned empty_results   = 0;
   int unsigned phase_count     = 0;
   int unsigned cycle_count     = 0;

   rle_mask_crop dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_run_length (req_run_length),
      .req_last_run   (req_last_run),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_length (rsp_out_length),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .rsp_out_empty  (rsp_out_empty),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned umin(input longint unsigned a, input longint unsigned b);
      return (a < b) ? a : b;
   endfunction

   task automatic add_due(input logic [CNT_W-1:0] len, input logic value, input logic is_last,
                          input logic is_empty);
      result_type r;
      r.out_length = len[OUT_LEN_BITS-1:0];
      r.out_value  = value;
      r.out_last   = is_last;
      r.out_empty  = is_empty;
      cropped_runs_due.push_back(r);
   endtask

   task automatic clear_scan();
      scan_pos       = '0;
      scan_parity    = 1'b0;
      held_len       = '0;
      held_val       = 1'b0;
      held_valid     = 1'b0;
      awaiting_first = 1'b1;
   endtask

   // Crop one accepted run against the clipped box and queue the runs it releases.
   task automatic crop_run(input logic [RUN_LEN_BITS-1:0] len, input logic is_last);
      longint unsigned  h, x0, y0, bw, bh, span;
      logic [CNT_W-1:0] from_pos, to_pos, box_first, box_end, rel_s, rel_e, kept_px;
      logic             run_val;
      h           = img_h;
      x0          = umin(left_col, img_w);
      y0          = umin(top_row, h);
      bw          = umin(crop_w, img_w - x0);
      bh          = umin(crop_h, h - y0);
      from_pos    = scan_pos;
      to_pos      = scan_pos + len;
      run_val     = scan_parity;
      scan_pos    = to_pos;
      scan_parity = ~scan_parity;
      // empty box (a zero image height lands here through bh): only the last run speaks
      if (bw == 0 || bh == 0) begin
         if (is_last) begin
            add_due('0, 1'b0, 1'b1, 1'b1);
            clear_scan();
         end
         return;
      end
      box_first = CNT_W'(x0 * h + y0);
      box_end   = CNT_W'((x0 + bw - 1) * h + bh + y0);
      span      = 0;
      if (to_pos > box_first && from_pos < box_end) begin
         rel_s = ((from_pos > box_first) ? from_pos : box_first) - box_first;
         rel_e = ((to_pos < box_end) ? to_pos : box_end) - box_first;
         span  = umin(rel_e % h, bh) + bh * (rel_e / h) - umin(rel_s % h, bh) - bh * (rel_s / h);
      end
      kept_px = CNT_W'(span);
      if (awaiting_first) begin
         // the first run is kept even when nothing of it lies in the box
         held_len       = kept_px;
         held_val       = run_val;
         held_valid     = 1'b1;
         awaiting_first = 1'b0;
      end else if (kept_px != 0) begin
         if (held_valid && run_val == held_val)
            held_len = held_len + kept_px;
         else begin
            if (held_valid)
               add_due(held_len, held_val, 1'b0, 1'b0);
            held_len   = kept_px;
            held_val   = run_val;
            held_valid = 1'b1;
         end
      end
      if (is_last) begin
         if (held_valid)
            add_due(held_len, held_val, 1'b1, 1'b0);
         else
            add_due('0, 1'b0, 1'b1, 1'b1);
         clear_scan();
      end
   endtask

   task automatic check_field(input string name, input logic [OUT_LEN_BITS-1:0] want,
                              input logic [OUT_LEN_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Driver: hold each run until accepted, predict on acceptance, then idle for the drawn gap.
   always @(posedge clock) begin : driver
      run_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            crop_run(req_run_length, req_last_run);
            runs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (runs_to_send.size() != 0) begin
               item = runs_to_send.pop_front();
               req_valid      <= 1'b1;
               req_run_length <= item.run_length;
               req_last_run   <= item.last_run;
               send_gap       <= send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result transaction with the oldest cropped run due, then stall.
   always @(posedge clock) begin : monitor
      result_type  want;
      int unsigned stall_left;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_wait <= 0;
      end else begin
         stall_left = ready_wait;
         if (rsp_valid && rsp_ready) begin
            if (cropped_runs_due.size() == 0) begin
               $display("%0t: result with nothing due, expected none actual %0h %b %b %b",
                        $time, rsp_out_length, rsp_out_value, rsp_out_last, rsp_out_empty);
               error_count++;
            end else begin
               want = cropped_runs_due.pop_front();
               check_field("out_length", want.out_length, rsp_out_length);
               check_field("out_value", want.out_value, rsp_out_value);
               check_field("out_last", want.out_last, rsp_out_last);
               check_field("out_empty", want.out_empty, rsp_out_empty);
            end
            results_checked++;
            if (rsp_out_empty)
               empty_results++;
            stall_left = recv_stall_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            ready_wait <= stall_left - 1;
         end else begin
            rsp_ready  <= 1'b1;
            ready_wait <= 0;
         end
      end
   end

   // Watchdog: end the run if the block stops making progress.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d runs pending and %0d results due", $time,
               runs_to_send.size(), cropped_runs_due.size());
      $display("rle_mask_crop_tb: errors");
      $finish;
   end

   // Issue one register write; the caller drops the write enable after its last write.
   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr, input logic [DIM_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_IMAGE_HEIGHT: img_h    = value;
         CSR_IMAGE_WIDTH:  img_w    = value;
         CSR_BOX_LEFT:     left_col = value;
         CSR_BOX_TOP:      top_row  = value;
         CSR_BOX_WIDTH:    crop_w   = value;
         CSR_BOX_HEIGHT:   crop_h   = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_box(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] l, input logic [DIM_W-1:0] t,
                          input logic [DIM_W-1:0] bw, input logic [DIM_W-1:0] bh);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_BOX_LEFT, l);
      write_csr(CSR_BOX_TOP, t);
      write_csr(CSR_BOX_WIDTH, bw);
      write_csr(CSR_BOX_HEIGHT, bh);
      csr_we <= 1'b0;
   endtask

   task automatic queue_run(input logic [RUN_LEN_BITS-1:0] len, input logic is_last);
      run_item_type item;
      item.run_length = len;
      item.last_run   = is_last;
      runs_to_send.push_back(item);
      runs_queued++;
      if (is_last)
         masks_queued++;
   endtask

   // Well-formed mask: split the image area into alternating runs, some of them empty.
   task automatic queue_mask(input logic [RUN_LEN_BITS-1:0] total, input int unsigned pieces);
      logic [RUN_LEN_BITS-1:0] rest, part;
      int unsigned             i;
      rest = total;
      for (i = 0; i < pieces; i++) begin
         if (i == pieces - 1)
            part = rest;
         else begin
            case ($urandom_range(0, 3))
               0:       part = '0;
               1:       part = RUN_LEN_BITS'(umin($urandom_range(1, 4), rest));
               default: part = $urandom_range(0, rest);
            endcase
         end
         rest = rest - part;
         queue_run(part, i == pieces - 1);
      end
   endtask

   // Noise: arbitrary lengths including the extremes, last flag at random.
   task automatic queue_noise(input int unsigned pieces);
      logic [RUN_LEN_BITS-1:0] len;
      repeat (pieces) begin
         case ($urandom_range(0, 4))
            0:       len = '0;
            1:       len = '1;
            2:       len = $urandom;
            default: len = $urandom_range(0, 30);
         endcase
         queue_run(len, $urandom_range(0, 3) == 0);
      end
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return DIM_W'(1);
         2:       return '1;
         default: return DIM_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Hold the sender until every run is accepted and every result has come back, then
   // let the block finish any run that yields nothing.
   task automatic drain();
      do
         @(negedge clock);
      while (runs_to_send.size() != 0 || req_valid || cropped_runs_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      phase_count++;
   endtask

   initial begin : stimulus
      int unsigned             kind, h, w, random_base;
      logic [RUN_LEN_BITS-1:0] cells;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: zero image height, so the mask crops to nothing
      queue_run('0, 1'b0);
      queue_run('1, 1'b1);
      drain();

      // small box inside a 4x4 image, zero-length first run kept, later runs merged
      set_box(4, 4, 1, 1, 2, 2);
      queue_run(0, 1'b0);
      queue_run(5, 1'b0);
      queue_run(3, 1'b0);
      queue_run(8, 1'b1);
      drain();

      // writes past the register file must leave the box as it is
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '0);
      csr_we <= 1'b0;
      queue_run(16, 1'b1);
      drain();

      // largest image and box, positions wrapping past the counter width
      set_box('1, '1, 0, 0, '1, '1);
      queue_run('1, 1'b0);
      queue_run('1, 1'b0);
      queue_run(5, 1'b1);
      drain();

      // change the box in the middle of a mask; the new box applies from the next run
      set_box(3, 3, 0, 0, 3, 3);
      queue_run(2, 1'b0);
      queue_run(3, 1'b0);
      drain();
      set_box(3, 3, 0, 1, 3, 1);
      queue_run(4, 1'b1);
      drain();

      // zero box width: held runs are dropped and the mask ends empty
      set_box(5, 5, 0, 0, 0, 5);
      queue_run(3, 1'b0);
      queue_run(4, 1'b0);
      queue_run(2, 1'b1);
      drain();

      // box starting past the right edge clips to nothing
      set_box(5, 5, '1, 0, 5, 5);
      queue_run(25, 1'b1);
      drain();

      // random phases: new box, idle pattern and a handful of masks or noise runs each
      random_base = runs_queued;
      while (runs_queued - random_base < RANDOM_RUNS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 7) begin
            h = (kind <= 5) ? $urandom_range(1, 12) : $urandom_range(1, 400);
            w = (kind <= 5) ? $urandom_range(1, 12) : $urandom_range(1, 400);
            set_box(DIM_W'(h), DIM_W'(w), DIM_W'($urandom_range(0, w + 1)),
                    DIM_W'($urandom_range(0, h + 1)), DIM_W'($urandom_range(0, w + 1)),
                    DIM_W'($urandom_range(0, h + 1)));
         end else if (kind == 8)
            set_box(pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_dim());
         else
            set_box(DIM_W'($urandom_range(0, 16'hFFFF)), DIM_W'($urandom_range(0, 16'hFFFF)),
                    DIM_W'($urandom_range(0, 16'hFFFF)), DIM_W'($urandom_range(0, 16'hFFFF)),
                    DIM_W'($urandom_range(0, 16'hFFFF)), DIM_W'($urandom_range(0, 16'hFFFF)));
         cells         = RUN_LEN_BITS'(img_h) * RUN_LEN_BITS'(img_w);
         send_idle_on  = $urandom_range(0, 3) != 0;
         recv_stall_on = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 4) != 0)
               queue_mask(cells, $urandom_range(1, 12));
            else
               queue_noise($urandom_range(1, 8));
         end
         drain();
      end

      $display("summary: %0d runs accepted in %0d phases, %0d masks terminated",
               runs_accepted, phase_count, masks_queued);
      $display("summary: %0d results checked, %0d of them empty, %0d mismatches",
               results_checked, empty_results, error_count);
      if (error_count == 0)
         $display("rle_mask_crop_tb: clean");
      else
         $display("rle_mask_crop_tb: errors");
      $finish;
   end

endmodule
